// ===== hw/rtl/svwm_pkg.sv =====
package svwm_pkg;

    localparam int SUM_W      = 16;
    localparam int CNT_W      = 5;
    localparam int VOLT_W     = 12;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // divider remainder width, enough for the larger divisor (125)
    localparam int REM_W      = 7;

    localparam int SCALE_MUL  = 121;
    localparam int SCALE_DIV  = 125;
    localparam int SCALE_OFS  = 67;
    // largest average whose scaled value still fits in 12 bits (gives 4095)
    localparam int AVG_SAT    = 4162;
    localparam int AVG_W      = 13;

    localparam logic [VOLT_W-1:0] WINDOW_HIGH_RST   = 12'd2200;
    localparam logic [VOLT_W-1:0] WINDOW_LOW_RST    = 12'd1700;
    localparam logic [VOLT_W-1:0] CUTOFF_LEVEL_RST  = 12'd500;
    localparam logic [VOLT_W-1:0] PRESENT_LEVEL_RST = 12'd700;
    localparam logic [HOLD_W-1:0] LOW_HOLD_RST      = 8'd10;
    localparam logic [HOLD_W-1:0] RECOVER_HOLD_RST  = 8'd5;
    localparam logic [HOLD_W-1:0] PRESENT_HOLD_RST  = 8'd5;
    localparam logic [HOLD_W-1:0] ABSENT_HOLD_RST   = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_HOLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_HOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_HOLD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_HOLD   = 3'd7;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_SET       = 2'd1;
    localparam logic [1:0] EV_CLR       = 2'd2;
    localparam logic [1:0] SUP_RETURNED = 2'd1;
    localparam logic [1:0] SUP_LOST     = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0] sample_sum;
        logic [CNT_W-1:0] sample_count;
    } t_in;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic              low_flag;
        logic              on_battery;
        logic [1:0]        low_event;
        logic [1:0]        supply_event;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [HOLD_W-1:0] cnt_set;
        logic [HOLD_W-1:0] cnt_clr;
        logic              flag;
        logic [1:0]        ev;
    } t_deb;

    function automatic logic [HOLD_W-1:0] f_bump(input logic [HOLD_W-1:0] c);
        return (c == {HOLD_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic t_deb f_debounce(
        input logic              cond,
        input logic [HOLD_W-1:0] cnt_set,
        input logic [HOLD_W-1:0] cnt_clr,
        input logic [HOLD_W-1:0] hold_set,
        input logic [HOLD_W-1:0] hold_clr,
        input logic              flag
    );
        t_deb d;
        d.cnt_set = cnt_set;
        d.cnt_clr = cnt_clr;
        d.flag    = flag;
        d.ev      = EV_NONE;
        if (cond) begin
            d.cnt_clr = '0;
            if (cnt_set > hold_set) begin
                if (!flag) begin
                    d.flag = 1'b1;
                    d.ev   = EV_SET;
                end
            end else begin
                d.cnt_set = f_bump(cnt_set);
            end
        end else begin
            d.cnt_set = '0;
            if (cnt_clr > hold_clr) begin
                if (flag) begin
                    d.flag = 1'b0;
                    d.ev   = EV_CLR;
                end
            end else begin
                d.cnt_clr = f_bump(cnt_clr);
            end
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/supply_voltage_window_monitor.sv =====
// an accepted input transaction runs through a restoring divide of the sum by
// the sample count (16 steps), a multiply by 121, a divide by 125 (12 steps),
// then debounce and output load; one bit-serial divider sets the pace
// the next input is held off until a result is loaded, but it is taken while that result waits
// reset: synchronous active low; thresholds and holds return to defaults,
// debounce counters and flags clear, no result pending
module supply_voltage_window_monitor import svwm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [SUM_W-1:0] r_q, n_q;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [REM_W-1:0] r_div, n_div;
    logic [3:0]       r_step, n_step;
    logic             r_cnt_zero, n_cnt_zero;

    t_out r_out, n_out;
    logic r_out_valid, n_out_valid;

    logic [HOLD_W-1:0] r_low_count, n_low_count;
    logic [HOLD_W-1:0] r_recover_count, n_recover_count;
    logic [HOLD_W-1:0] r_present_count, n_present_count;
    logic [HOLD_W-1:0] r_absent_count, n_absent_count;
    logic              r_low_state, n_low_state;
    logic              r_battery_state, n_battery_state;

    logic [VOLT_W-1:0] r_window_high, r_window_low, r_cutoff, r_present;
    logic [HOLD_W-1:0] r_low_hold, r_recover_hold, r_present_hold, r_absent_hold;

    // one restoring divide step, shared by both divide phases
    logic [REM_W:0]    w_trial;
    logic              w_ge;
    logic [REM_W-1:0]  w_rem_nx;

    logic [AVG_W-1:0]  w_avg;
    logic [AVG_W+6:0]  w_prod;

    logic [VOLT_W-1:0] w_scaled;
    logic [VOLT_W-1:0] w_volt;
    t_deb              w_low_deb;
    t_deb              w_sup_deb;

    assign w_trial  = {r_rem, r_q[SUM_W-1]};
    assign w_ge     = w_trial >= {1'b0, r_div};
    assign w_rem_nx = w_ge ? REM_W'(w_trial - {1'b0, r_div}) : w_trial[REM_W-1:0];

    // clamping the average keeps the product narrow; anything above saturates at 4095
    assign w_avg = r_cnt_zero ? '0 :
                   (r_q > SUM_W'(AVG_SAT)) ? AVG_W'(AVG_SAT) : r_q[AVG_W-1:0];
    // times 121 as 128 - 8 + 1
    assign w_prod = {w_avg, 7'd0} - {4'd0, w_avg, 3'd0} + {7'd0, w_avg};

    assign w_scaled = r_q[VOLT_W-1:0] + VOLT_W'(SCALE_OFS);
    assign w_volt   = (w_scaled < r_cutoff) ? '0 : w_scaled;

    assign w_low_deb = f_debounce((w_volt < r_window_high) && (w_volt > r_window_low),
                                  r_low_count, r_recover_count,
                                  r_low_hold, r_recover_hold, r_low_state);
    // set side of the supply detector is the supply being absent
    assign w_sup_deb = f_debounce(!(w_volt > r_present),
                                  r_absent_count, r_present_count,
                                  r_absent_hold, r_present_hold, r_battery_state);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_q             = r_q;
        n_rem           = r_rem;
        n_div           = r_div;
        n_step          = r_step;
        n_cnt_zero      = r_cnt_zero;
        n_out           = r_out;
        n_out_valid     = r_out_valid && i_out_stall;
        n_low_count     = r_low_count;
        n_recover_count = r_recover_count;
        n_present_count = r_present_count;
        n_absent_count  = r_absent_count;
        n_low_state     = r_low_state;
        n_battery_state = r_battery_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_q        = i_in.sample_sum;
                    n_rem      = '0;
                    n_div      = REM_W'(i_in.sample_count);
                    n_cnt_zero = (i_in.sample_count == '0);
                    n_step     = 4'(SUM_W - 1);
                    n_state    = S_DIV;
                end
            end
            S_DIV, S_SCALE: begin
                n_rem  = w_rem_nx;
                n_q    = {r_q[SUM_W-2:0], w_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = (r_state == S_DIV) ? S_MUL : S_FINISH;
                end
            end
            S_MUL: begin
                // product < 125 * 4096, so its top bits already form the remainder seed
                n_rem   = w_prod[AVG_W+5:VOLT_W];
                n_q     = {w_prod[VOLT_W-1:0], {(SUM_W-VOLT_W){1'b0}}};
                n_div   = REM_W'(SCALE_DIV);
                n_step  = 4'(VOLT_W - 1);
                n_state = S_SCALE;
            end
            S_FINISH: begin
                if (!n_out_valid) begin
                    n_out.voltage      = w_volt;
                    n_out.low_flag     = w_low_deb.flag;
                    n_out.on_battery   = w_sup_deb.flag;
                    n_out.low_event    = w_low_deb.ev;
                    n_out.supply_event = (w_sup_deb.ev == EV_SET) ? SUP_LOST :
                                         (w_sup_deb.ev == EV_CLR) ? SUP_RETURNED : EV_NONE;
                    n_out_valid        = 1'b1;
                    n_low_count        = w_low_deb.cnt_set;
                    n_recover_count    = w_low_deb.cnt_clr;
                    n_low_state        = w_low_deb.flag;
                    n_absent_count     = w_sup_deb.cnt_set;
                    n_present_count    = w_sup_deb.cnt_clr;
                    n_battery_state    = w_sup_deb.flag;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_low_count     <= '0;
            r_recover_count <= '0;
            r_present_count <= '0;
            r_absent_count  <= '0;
            r_low_state     <= 1'b0;
            r_battery_state <= 1'b0;
        end else begin
            r_out_valid     <= n_out_valid;
            r_low_count     <= n_low_count;
            r_recover_count <= n_recover_count;
            r_present_count <= n_present_count;
            r_absent_count  <= n_absent_count;
            r_low_state     <= n_low_state;
            r_battery_state <= n_battery_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_step     <= n_step;
        r_cnt_zero <= n_cnt_zero;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_high  <= WINDOW_HIGH_RST;
            r_window_low   <= WINDOW_LOW_RST;
            r_cutoff       <= CUTOFF_LEVEL_RST;
            r_present      <= PRESENT_LEVEL_RST;
            r_low_hold     <= LOW_HOLD_RST;
            r_recover_hold <= RECOVER_HOLD_RST;
            r_present_hold <= PRESENT_HOLD_RST;
            r_absent_hold  <= ABSENT_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_HIGH:   r_window_high  <= i_cfg_data[VOLT_W-1:0];
                CFG_WINDOW_LOW:    r_window_low   <= i_cfg_data[VOLT_W-1:0];
                CFG_CUTOFF_LEVEL:  r_cutoff       <= i_cfg_data[VOLT_W-1:0];
                CFG_PRESENT_LEVEL: r_present      <= i_cfg_data[VOLT_W-1:0];
                CFG_LOW_HOLD:      r_low_hold     <= i_cfg_data[HOLD_W-1:0];
                CFG_RECOVER_HOLD:  r_recover_hold <= i_cfg_data[HOLD_W-1:0];
                CFG_PRESENT_HOLD:  r_present_hold <= i_cfg_data[HOLD_W-1:0];
                CFG_ABSENT_HOLD:   r_absent_hold  <= i_cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // second divide phase always starts and stays below its divisor
    a_scale_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> (r_rem < REM_W'(SCALE_DIV)))
        else $error("scale divider remainder out of range");

    a_volt_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.voltage != '0)) |-> (o_out.voltage >= VOLT_W'(SCALE_OFS)))
        else $error("nonzero voltage below offset");

    a_low_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.low_event == EV_SET)) |-> o_out.low_flag)
        else $error("low event without low flag");

    a_supply_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.supply_event == SUP_LOST)) |-> o_out.on_battery)
        else $error("supply lost event without battery flag");

endmodule
